>>> design/tcms_pkg.sv
// ----------------------------------------------------------------------------
// tcms_pkg
// shared types and constants for the tour cost minimum search block
// ----------------------------------------------------------------------------
package tcms_pkg;

	localparam int MAX_NODES_DEF   = 16;
	localparam int WEIGHT_BITS_DEF = 16;

	localparam int NODE_FIELD_W = 4;
	localparam int EDGE_FIELD_W = 16;
	localparam int SUM_W        = 20;
	localparam int COUNT_W      = 32;
	localparam int IN_DATA_W    = 32;
	localparam int OUT_DATA_W   = 104;

	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_NODE  = 2'd1,
		MODE_START = 2'd2
	} mode_t;

	typedef struct packed {
		logic tour;
		logic clr;
		logic first;
		logic last;
		logic ok_a;
		logic ok_b;
	} node_ctrl_t;

	typedef struct packed {
		logic res;
		logic clr;
	} res_ctrl_t;

endpackage

>>> design/tcms_ram.sv
// ----------------------------------------------------------------------------
// tcms_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tcms_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> design/tcms_accum.sv
// ----------------------------------------------------------------------------
// tcms_accum
// running edge sum per tour node and closing-edge add for the last node
// ----------------------------------------------------------------------------
module tcms_accum #(
	parameter int WEIGHT_BITS = tcms_pkg::WEIGHT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  tcms_pkg::node_ctrl_t      ctrl_s1,
	input  logic [WEIGHT_BITS-1:0]    rd_a,
	input  logic [WEIGHT_BITS-1:0]    rd_b,
	output tcms_pkg::res_ctrl_t       res_s3,
	output logic [tcms_pkg::SUM_W-1:0] cost_s3
);

	import tcms_pkg::*;

	localparam int ADD_W = ((WEIGHT_BITS > SUM_W) ? WEIGHT_BITS : SUM_W) + 1;

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
			input logic [WEIGHT_BITS-1:0] w);
		logic [ADD_W-1:0] t;
		t = ADD_W'(s) + ADD_W'(w);
		if (t > ADD_W'(SUM_MAX)) begin
			return SUM_MAX;
		end
		return t[SUM_W-1:0];
	endfunction

	logic [SUM_W-1:0]       sum_q;
	logic [SUM_W-1:0]       new_sum;
	logic [WEIGHT_BITS-1:0] wa;
	logic [WEIGHT_BITS-1:0] wb;
	res_ctrl_t              res_s2;
	logic [SUM_W-1:0]       sum_s2;
	logic [WEIGHT_BITS-1:0] wb_s2;

	assign wa      = ctrl_s1.ok_a ? rd_a : '0;
	assign wb      = ctrl_s1.ok_b ? rd_b : '0;
	assign new_sum = ctrl_s1.first ? '0 : sat_add(sum_q, wa);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			res_s2  <= '0;
			res_s3  <= '0;
		end else if (en) begin
			if (ctrl_s1.tour) begin
				sum_q <= new_sum;
			end
			res_s2.res <= ctrl_s1.tour && ctrl_s1.last;
			res_s2.clr <= ctrl_s1.clr;
			res_s3     <= res_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= new_sum;
			wb_s2   <= wb;
			cost_s3 <= sat_add(sum_s2, wb_s2);
		end
	end

endmodule

>>> design/tcms_best.sv
// ----------------------------------------------------------------------------
// tcms_best
// tour count, running minimum and output register with skid stage
// ----------------------------------------------------------------------------
module tcms_best (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tcms_pkg::res_ctrl_t            res_s3,
	input  logic [tcms_pkg::SUM_W-1:0]     cost_s3,
	output logic                           en,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// tour_cost, tour_number, best_cost, best_number
	output logic [tcms_pkg::OUT_DATA_W-1:0] m_tdata
);

	import tcms_pkg::*;

	logic [COUNT_W-1:0]    count_q;
	logic [SUM_W:0]        best_q;
	logic [COUNT_W-1:0]    best_num_q;
	logic                  take;
	logic [SUM_W:0]        best_d;
	logic [COUNT_W-1:0]    best_num_d;
	logic                  push;
	logic [OUT_DATA_W-1:0] res_data;
	logic [OUT_DATA_W-1:0] out_q;
	logic [OUT_DATA_W-1:0] skid_q;
	logic                  out_valid_q;
	logic                  skid_valid_q;

	assign en         = !skid_valid_q;
	assign push       = en && res_s3.res;
	assign take       = {1'b0, cost_s3} <= best_q;
	assign best_d     = take ? {1'b0, cost_s3} : best_q;
	assign best_num_d = take ? count_q : best_num_q;
	assign res_data   = {best_num_d, best_d[SUM_W-1:0], count_q, cost_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			best_q     <= '1;
			best_num_q <= '0;
		end else if (en) begin
			if (res_s3.clr) begin
				count_q <= '0;
				best_q  <= '1;
			end else if (res_s3.res) begin
				count_q    <= count_q + COUNT_W'(1);
				best_q     <= best_d;
				best_num_q <= best_num_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || m_tready) begin
				if (skid_valid_q) begin
					skid_valid_q <= 1'b0;
					out_valid_q  <= 1'b1;
				end else begin
					out_valid_q <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res_data;
			end
		end else if (push) begin
			skid_q <= res_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

>>> design/tour_cost_minimum_search.sv
// ----------------------------------------------------------------------------
// tour_cost_minimum_search
// edge-weight store and evaluator of candidate tours with running minimum
// ----------------------------------------------------------------------------
// One input transaction is taken every cycle while not stalled: weight loads,
// tour nodes and start commands alike. Each tour node reads two copies of the
// weight ram in the same cycle, one for the edge from the previous node and
// one for the closing edge back to the first node, so the single read port of
// each copy sets the rate. A last node's result passes the ram read, s2, s3
// and output registers; the block only stops taking input when both the
// output register and its skid stage hold results. No clearing pass is run.
module tour_cost_minimum_search #(
	parameter int MAX_NODES   = tcms_pkg::MAX_NODES_DEF,
	parameter int WEIGHT_BITS = tcms_pkg::WEIGHT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// mode, from_node, to_node, edge_weight, tour_node
	input  logic [tcms_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            s_tlast,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// tour_cost, tour_number, best_cost, best_number
	output logic [tcms_pkg::OUT_DATA_W-1:0] m_tdata
);

	import tcms_pkg::*;

	localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int ADDR_W = 2 * NODE_W;
	localparam int DEPTH  = 1 << ADDR_W;
	localparam int CMP_W  = NODE_FIELD_W + 4;

	function automatic logic node_ok(input logic [NODE_FIELD_W-1:0] n);
		return CMP_W'(n) < CMP_W'(MAX_NODES);
	endfunction

	function automatic logic [NODE_W-1:0] node_idx(input logic [NODE_FIELD_W-1:0] n);
		logic [NODE_W+NODE_FIELD_W-1:0] e;
		e = {{NODE_W{1'b0}}, n};
		return e[NODE_W-1:0];
	endfunction

	mode_t                          mode;
	logic [NODE_FIELD_W-1:0]        from_node;
	logic [NODE_FIELD_W-1:0]        to_node;
	logic [EDGE_FIELD_W-1:0]        edge_weight;
	logic [NODE_FIELD_W-1:0]        tour_node;
	logic [WEIGHT_BITS+EDGE_FIELD_W-1:0] weight_ext;

	logic                    en;
	logic                    acc;
	logic                    we;
	logic [ADDR_W-1:0]       waddr;
	logic [ADDR_W-1:0]       raddr_a;
	logic [ADDR_W-1:0]       raddr_b;
	logic [WEIGHT_BITS-1:0]  rd_a;
	logic [WEIGHT_BITS-1:0]  rd_b;
	logic [NODE_FIELD_W-1:0] first_q;
	logic [NODE_FIELD_W-1:0] prev_q;
	logic                    in_tour_q;
	logic [NODE_FIELD_W-1:0] first_eff;
	node_ctrl_t              ctrl_d;
	node_ctrl_t              ctrl_s1;
	res_ctrl_t               res_s3;
	logic [SUM_W-1:0]        cost_s3;

	assign mode        = mode_t'(s_tdata[1:0]);
	assign from_node   = s_tdata[5:2];
	assign to_node     = s_tdata[9:6];
	assign edge_weight = s_tdata[25:10];
	assign tour_node   = s_tdata[29:26];
	assign weight_ext  = {{WEIGHT_BITS{1'b0}}, edge_weight};

	assign s_tready  = en;
	assign acc       = s_tvalid && en;
	assign first_eff = in_tour_q ? first_q : tour_node;

	assign we      = acc && (mode == MODE_LOAD) && node_ok(from_node) && node_ok(to_node);
	assign waddr   = {node_idx(from_node), node_idx(to_node)};
	assign raddr_a = {node_idx(prev_q), node_idx(tour_node)};
	assign raddr_b = {node_idx(tour_node), node_idx(first_eff)};

	always_comb begin
		ctrl_d       = '0;
		ctrl_d.first = !in_tour_q;
		ctrl_d.last  = s_tlast;
		ctrl_d.ok_a  = node_ok(prev_q) && node_ok(tour_node);
		ctrl_d.ok_b  = node_ok(tour_node) && node_ok(first_eff);
		case (mode)
			MODE_NODE: begin
				ctrl_d.tour = acc;
			end
			MODE_START: begin
				ctrl_d.clr = acc;
			end
			default: begin
				ctrl_d.tour = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q   <= '0;
			prev_q    <= '0;
			in_tour_q <= 1'b0;
			ctrl_s1   <= '0;
		end else if (en) begin
			ctrl_s1 <= ctrl_d;
			if (acc) begin
				case (mode)
					MODE_NODE: begin
						first_q   <= first_eff;
						prev_q    <= tour_node;
						in_tour_q <= !s_tlast;
					end
					MODE_START: begin
						in_tour_q <= 1'b0;
					end
					default: begin
						in_tour_q <= in_tour_q;
					end
				endcase
			end
		end
	end

	tcms_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (DEPTH)
	) u_ram_a (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (weight_ext[WEIGHT_BITS-1:0]),
		.re    (en),
		.raddr (raddr_a),
		.rdata (rd_a)
	);

	tcms_ram #(
		.WIDTH (WEIGHT_BITS),
		.DEPTH (DEPTH)
	) u_ram_b (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (weight_ext[WEIGHT_BITS-1:0]),
		.re    (en),
		.raddr (raddr_b),
		.rdata (rd_b)
	);

	tcms_accum #(
		.WEIGHT_BITS (WEIGHT_BITS)
	) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctrl_s1 (ctrl_s1),
		.rd_a    (rd_a),
		.rd_b    (rd_b),
		.res_s3  (res_s3),
		.cost_s3 (cost_s3)
	);

	tcms_best u_best (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_s3   (res_s3),
		.cost_s3  (cost_s3),
		.en       (en),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result waiting");

	a_best_not_above_cost: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[71:52] <= m_tdata[19:0]))
		else $error("best cost above the cost of the emitted tour");

	a_start_ends_tour: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (mode == MODE_START)) |=> !in_tour_q)
		else $error("start transaction left a tour open");

endmodule

>>> tb/sv/tcms_checker.sv
// ----------------------------------------------------------------------------
// tcms_checker
// watches both stream channels of the tour cost search and checks each result
// ----------------------------------------------------------------------------
// Every accepted input transaction runs through a local copy of the weight
// store and the tour accumulator. A finished tour pushes its expected cost,
// number and running best into a queue. Each accepted output transaction is
// compared field by field with the oldest entry of that queue.
module tcms_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [tcms_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            s_tlast,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [tcms_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                              errors,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tcms_pkg::*;

	localparam logic [SUM_W:0] BEST_NONE = '1;

	typedef struct packed {
		logic [COUNT_W-1:0] best_number;
		logic [SUM_W-1:0]   best_cost;
		logic [COUNT_W-1:0] tour_number;
		logic [SUM_W-1:0]   tour_cost;
	} tour_result_t;

	logic [EDGE_FIELD_W-1:0] weights [0:255];
	logic [NODE_FIELD_W-1:0] first_node;
	logic [NODE_FIELD_W-1:0] prev_node;
	logic                    in_tour;
	logic [SUM_W-1:0]        run_sum;
	logic [COUNT_W-1:0]      tours_done;
	logic [SUM_W:0]          best_cost;
	logic [COUNT_W-1:0]      best_tour;
	tour_result_t            tour_results_q [$];

	function automatic logic [SUM_W-1:0] sat_add(logic [SUM_W-1:0] sum,
			logic [EDGE_FIELD_W-1:0] w);
		logic [SUM_W:0] t;
		t = {1'b0, sum} + (SUM_W+1)'(w);
		return (t > {1'b0, SUM_MAX}) ? SUM_MAX : t[SUM_W-1:0];
	endfunction

	task automatic check_field(string name, logic [COUNT_W-1:0] want,
			logic [COUNT_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic evaluate_item(logic [IN_DATA_W-1:0] data, logic lst);
		logic [1:0]              mode;
		logic [NODE_FIELD_W-1:0] from_n;
		logic [NODE_FIELD_W-1:0] to_n;
		logic [EDGE_FIELD_W-1:0] w;
		logic [NODE_FIELD_W-1:0] node;
		tour_result_t            res;
		mode   = data[1:0];
		from_n = data[5:2];
		to_n   = data[9:6];
		w      = data[25:10];
		node   = data[29:26];
		case (mode)
			MODE_LOAD: begin
				weights[{from_n, to_n}] = w;
			end
			MODE_START: begin
				best_cost  = BEST_NONE;
				tours_done = '0;
				in_tour    = 1'b0;
				run_sum    = '0;
			end
			MODE_NODE: begin
				if (!in_tour) begin
					first_node = node;
					run_sum    = '0;
					in_tour    = 1'b1;
				end else begin
					run_sum = sat_add(run_sum, weights[{prev_node, node}]);
				end
				prev_node = node;
				if (lst) begin
					run_sum = sat_add(run_sum, weights[{node, first_node}]);
					// later tour wins a tie
					if ({1'b0, run_sum} <= best_cost) begin
						best_cost = {1'b0, run_sum};
						best_tour = tours_done;
					end
					res.tour_cost   = run_sum;
					res.tour_number = tours_done;
					res.best_cost   = best_cost[SUM_W-1:0];
					res.best_number = best_tour;
					tour_results_q.push_back(res);
					tours_done++;
					in_tour = 1'b0;
					run_sum = '0;
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		tour_result_t got;
		tour_result_t want;
		if (!arst_n) begin
			first_node = '0;
			prev_node  = '0;
			in_tour    = 1'b0;
			run_sum    = '0;
			tours_done = '0;
			best_cost  = BEST_NONE;
			best_tour  = '0;
			tour_results_q.delete();
			errors     = 0;
			pending   <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (tour_results_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got cost %0d number %0d",
						$time, got.tour_cost, got.tour_number);
					errors++;
				end else begin
					want = tour_results_q.pop_front();
					check_field("tour_cost", COUNT_W'(want.tour_cost),
						COUNT_W'(got.tour_cost));
					check_field("tour_number", want.tour_number, got.tour_number);
					check_field("best_cost", COUNT_W'(want.best_cost),
						COUNT_W'(got.best_cost));
					check_field("best_number", want.best_number, got.best_number);
				end
			end
			if (s_tvalid && s_tready)
				evaluate_item(s_tdata, s_tlast);
			pending <= tour_results_q.size();
		end
	end

endmodule

>>> tb/sv/tb_tour_cost_minimum_search.sv
// ----------------------------------------------------------------------------
// tb_tour_cost_minimum_search
// stimulus and verdict for the tour cost minimum search block
// ----------------------------------------------------------------------------
// Loads edge weights and streams candidate tours: first a directed set with
// extreme weights, single-node tours, a tie, a saturating tour and a search
// restart mid-tour, then random tours with loads, restarts and ignored items
// mixed in. A weight a tour reads, if not yet written, is loaded just before
// the node that needs it, so loads also land mid-tour. The sender runs in
// bursts, the receiver stalls in phases, and the checker does the comparing.
module tb_tour_cost_minimum_search;
	timeunit 1ns;
	timeprecision 1ps;

	import tcms_pkg::*;

	localparam logic [1:0] MODE_IGNORED = 2'd3;
	localparam int         NUM_ITEMS    = 450;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	int                    errors;
	int                    pending;

	bit                    written [0:255];
	logic                  tr_in_tour;
	logic [3:0]            tr_first;
	logic [3:0]            tr_prev;
	int                    burst_left;
	int                    n_items;

	tour_cost_minimum_search i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	tcms_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tour_cost_minimum_search test failed");
		$finish;
	end

	// receiver stalls in phases: always ready, coin flip, mostly stalled
	always @(posedge clk or negedge arst_n) begin
		int phase_left;
		int stall_style;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			phase_left = 0;
		end else begin
			if (phase_left == 0) begin
				stall_style = $urandom_range(0, 2);
				phase_left  = $urandom_range(16, 96);
			end
			phase_left--;
			case (stall_style)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	function automatic logic [15:0] rand_weight();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 15));
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [3:0] pick_node();
		return 4'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15));
	endfunction

	task automatic push(logic [1:0] mode, logic [3:0] from_n, logic [3:0] to_n,
			logic [15:0] w, logic [3:0] node, logic lst);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, node, w, to_n, from_n, mode};
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		if (mode != MODE_IGNORED)
			n_items++;
	endtask

	task automatic load_entry(logic [3:0] from_n, logic [3:0] to_n, logic [15:0] w);
		push(MODE_LOAD, from_n, to_n, w, 4'($urandom), 1'($urandom));
		written[{from_n, to_n}] = 1'b1;
	endtask

	task automatic start_search();
		push(MODE_START, 4'($urandom), 4'($urandom), 16'($urandom), 4'($urandom),
			1'($urandom));
		tr_in_tour = 1'b0;
	endtask

	task automatic send_ignored();
		push(MODE_IGNORED, 4'($urandom), 4'($urandom), 16'($urandom), 4'($urandom),
			1'($urandom));
	endtask

	// loads any unwritten weight the node will read before sending it
	task automatic tour_step(logic [3:0] node, logic lst);
		logic [3:0] head;
		if (tr_in_tour && !written[{tr_prev, node}])
			load_entry(tr_prev, node, rand_weight());
		head = tr_in_tour ? tr_first : node;
		if (lst && !written[{node, head}])
			load_entry(node, head, rand_weight());
		push(MODE_NODE, 4'($urandom), 4'($urandom), 16'($urandom), node, lst);
		if (!tr_in_tour)
			tr_first = node;
		tr_prev    = node;
		tr_in_tour = !lst;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int  tour_len;
		bit  paused;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tlast    = 1'b0;
		tr_in_tour = 1'b0;
		tr_first   = '0;
		tr_prev    = '0;
		burst_left = 0;
		n_items    = 0;
		paused     = 1'b0;
		foreach (written[i]) written[i] = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_entry(4'd0, 4'd0, 16'hFFFF);
		load_entry(4'd15, 4'd15, 16'h0000);
		load_entry(4'd0, 4'd15, 16'h0001);
		load_entry(4'd15, 4'd0, 16'h8000);
		tour_step(4'd15, 1'b1);
		tour_step(4'd0, 1'b0);
		tour_step(4'd15, 1'b1);
		send_ignored();
		// tie with the first tour
		tour_step(4'd15, 1'b1);
		// seventeen heavy edges saturate the sum
		repeat (16) tour_step(4'd0, 1'b0);
		tour_step(4'd0, 1'b1);
		tour_step(4'd0, 1'b0);
		tour_step(4'd15, 1'b0);
		start_search();
		tour_step(4'd15, 1'b1);

		while (n_items < NUM_ITEMS) begin
			if (!paused && n_items >= NUM_ITEMS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
			case ($urandom_range(0, 19))
				0: start_search();
				1: send_ignored();
				2, 3: load_entry(4'($urandom), 4'($urandom), rand_weight());
				default: begin
					tour_len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
						: $urandom_range(1, 5);
					for (int k = 0; k < tour_len; k++) begin
						case ($urandom_range(0, 39))
							0: start_search();
							1: send_ignored();
							2, 3: load_entry(4'($urandom), 4'($urandom), rand_weight());
							default: begin
							end
						endcase
						tour_step(pick_node(), k == tour_len - 1);
					end
				end
			endcase
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("tour_cost_minimum_search test passed");
		else
			$display("tour_cost_minimum_search test failed");
		$finish;
	end

endmodule

>>> tour_cost_minimum_search.f
design/tcms_pkg.sv
design/tcms_ram.sv
design/tcms_accum.sv
design/tcms_best.sv
design/tour_cost_minimum_search.sv
tb/sv/tcms_checker.sv
tb/sv/tb_tour_cost_minimum_search.sv
